/* design/cat_frequency_band_decoder_core_assert.svh */
// Assertion macros for the band decoder core.
`ifndef CAT_FREQUENCY_BAND_DECODER_CORE_ASSERT_SVH
`define CAT_FREQUENCY_BAND_DECODER_CORE_ASSERT_SVH
`ifndef SYNTH
`define CFBD_ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CFBD_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CFBD_ASSERT_PROP(label, clk, rst, prop, msg)
`define CFBD_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

/* design/cfbd_pkg.sv */
`default_nettype none

package cfbd_pkg;

   localparam int BAND_COUNT     = 5;
   localparam int SLOTS_PER_BAND = 16;
   localparam int LINE_LENGTH    = 64;

   localparam int BYTE_W  = 8;
   localparam int BAND_W  = 3;
   localparam int SLOT_W  = 4;
   localparam int MHZ_W   = 7;
   localparam int RELAY_W = 5;

   localparam int SLOT_AW     = (SLOTS_PER_BAND > 1) ? $clog2(SLOTS_PER_BAND) : 1;
   localparam int BAND_AW     = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
   localparam int TABLE_DEPTH = BAND_COUNT << SLOT_AW;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

   localparam int POS_W     = $clog2(LINE_LENGTH);
   localparam int HEAD_LEN  = 7;
   localparam int HEAD_AW   = 3;
   localparam int FRAME_LEN = 14;

   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic MODE_RADIO = 1'b0;
   localparam logic MODE_ENTRY = 1'b1;

   typedef struct packed {
      logic               message_done;
      logic [MHZ_W-1:0]   mhz;
      logic               band_found;
      logic [BAND_W-1:0]  band;
      logic               relay_change;
      logic [RELAY_W-1:0] relay_onehot;
   } result_type;

endpackage

`default_nettype wire

/* design/cfbd_ifs.sv */
`default_nettype none

interface cfbd_req_if;
   logic                              valid;
   logic                              ready;
   logic                              mode;
   logic [cfbd_pkg::BYTE_W-1:0]       rx_byte;
   logic                              auto_selected;
   logic [cfbd_pkg::BAND_W-1:0]       entry_band;
   logic [cfbd_pkg::SLOT_W-1:0]       entry_slot;
   logic [cfbd_pkg::MHZ_W-1:0]        entry_mhz;
   logic                              entry_valid;

   modport source (output valid, mode, rx_byte, auto_selected, entry_band, entry_slot,
                   entry_mhz, entry_valid, input ready);
   modport sink   (input valid, mode, rx_byte, auto_selected, entry_band, entry_slot,
                   entry_mhz, entry_valid, output ready);
endinterface

interface cfbd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              message_done;
   logic [cfbd_pkg::MHZ_W-1:0]        mhz;
   logic                              band_found;
   logic [cfbd_pkg::BAND_W-1:0]       band;
   logic                              relay_change;
   logic [cfbd_pkg::RELAY_W-1:0]      relay_onehot;

   modport source (output valid, message_done, mhz, band_found, band, relay_change,
                   relay_onehot, input ready);
   modport sink   (input valid, message_done, mhz, band_found, band, relay_change,
                   relay_onehot, output ready);
endinterface

`default_nettype wire

/* design/cat_frequency_band_decoder_core.sv */
// Band decoder: watches radio bytes for "FA000mmdddddd;" reports, decodes the
// megahertz pair and, in auto mode, finds the first valid band table entry
// holding that value and drives a one-hot relay word when the band changes.
// One item is worked on at a time. Table writes and radio bytes that need no
// lookup have their result registered straight from the accepting cycle. A
// frame end with auto selected and a nonzero megahertz value scans the band
// table RAM one entry per cycle through its single read port, in band-major
// order, stopping at the first match or after all 80 entries. No item is taken
// while a result waits to be collected; the input is ready again in the cycle
// that result is collected.
`default_nettype none

`include "cat_frequency_band_decoder_core_assert.svh"

module cat_frequency_band_decoder_core (
   input wire logic clock,
   input wire logic reset,
   cfbd_req_if.sink   req_ch,
   cfbd_rsp_if.source rsp_ch
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [cfbd_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [7:0]                          head_ff [cfbd_pkg::HEAD_LEN];
   logic [7:0]                          head_in [cfbd_pkg::HEAD_LEN];
   logic [cfbd_pkg::TABLE_DEPTH-1:0]    valid_ff, valid_in;
   logic                                last_valid_ff, last_valid_in;
   logic [cfbd_pkg::BAND_W-1:0]         last_band_ff, last_band_in;
   logic [cfbd_pkg::MHZ_W-1:0]          mhz_ff, mhz_in;
   logic [cfbd_pkg::BAND_AW-1:0]        scan_band_ff, scan_band_in;
   logic [cfbd_pkg::SLOT_AW-1:0]        scan_slot_ff, scan_slot_in;
   logic                                issue_done_ff, issue_done_in;
   logic                                pend_ff, pend_in;
   logic                                pend_valid_ff, pend_valid_in;
   logic [cfbd_pkg::BAND_AW-1:0]        pend_band_ff, pend_band_in;
   logic                                found_ff, found_in;
   logic [cfbd_pkg::BAND_AW-1:0]        found_band_ff, found_band_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   cfbd_pkg::result_type                rsp_data_ff, rsp_data_in;

   logic                                accept;
   logic                                rsp_free;
   logic [7:0]                          c;
   logic [cfbd_pkg::POS_W-1:0]          pos_base;
   logic [cfbd_pkg::POS_W-1:0]          pos_next;
   logic                                prefix_ok;
   logic                                frame_done;
   logic [cfbd_pkg::MHZ_W-1:0]          mhz_dec;
   logic                                entry_ok;
   logic [cfbd_pkg::TABLE_AW-1:0]       wr_addr;
   logic [cfbd_pkg::TABLE_AW-1:0]       rd_addr;
   logic                                wr_en;
   logic                                rd_en;
   logic [cfbd_pkg::MHZ_W-1:0]          rd_data;
   logic                                last_slot;
   logic                                last_band_slot;
   logic [cfbd_pkg::BAND_W-1:0]         fin_band;
   logic                                fin_change;

   function automatic logic is_digit(input logic [7:0] ch);
      return ch inside {[cfbd_pkg::CHAR_0:cfbd_pkg::CHAR_9]};
   endfunction

   function automatic logic [cfbd_pkg::MHZ_W-1:0] decode_two(input logic [7:0] a,
                                                            input logic [7:0] b);
      logic [3:0]                 av;
      logic [3:0]                 bv;
      logic [cfbd_pkg::MHZ_W-1:0] r;
      av = 4'(a - cfbd_pkg::CHAR_0);
      bv = 4'(b - cfbd_pkg::CHAR_0);
      r  = '0;
      if (a inside {cfbd_pkg::CHAR_SPACE, cfbd_pkg::CHAR_PLUS,
                    [cfbd_pkg::CHAR_TAB:cfbd_pkg::CHAR_CR]}) begin
         r = is_digit(b) ? cfbd_pkg::MHZ_W'(bv) : '0;
      end else if (a == cfbd_pkg::CHAR_MINUS) begin
         r = '0;
      end else if (is_digit(a)) begin
         r = is_digit(b) ?
             cfbd_pkg::MHZ_W'(cfbd_pkg::MHZ_W'(av) * 7'd10 + cfbd_pkg::MHZ_W'(bv)) :
             cfbd_pkg::MHZ_W'(av);
      end
      return r;
   endfunction

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept       = req_ch.valid && req_ch.ready;

   // radio byte parsing
   assign c          = req_ch.rx_byte;
   assign pos_base   = (c == cfbd_pkg::CHAR_F) ? '0 : pos_ff;
   assign pos_next   = (pos_base < cfbd_pkg::POS_W'(cfbd_pkg::LINE_LENGTH - 1)) ?
                       cfbd_pkg::POS_W'(pos_base + 1'b1) : '0;
   assign prefix_ok  = (head_ff[0] == cfbd_pkg::CHAR_F) && (head_ff[1] == cfbd_pkg::CHAR_A) &&
                       (head_ff[2] == cfbd_pkg::CHAR_0) && (head_ff[3] == cfbd_pkg::CHAR_0) &&
                       (head_ff[4] == cfbd_pkg::CHAR_0);
   assign frame_done = (c == cfbd_pkg::CHAR_SEMI) &&
                       (pos_next == cfbd_pkg::POS_W'(cfbd_pkg::FRAME_LEN));
   assign mhz_dec    = (frame_done && prefix_ok) ? decode_two(head_ff[5], head_ff[6]) : '0;

   // table write
   assign entry_ok = ({1'b0, req_ch.entry_band} < 4'(cfbd_pkg::BAND_COUNT)) &&
                     ({2'b00, req_ch.entry_slot} < 6'(cfbd_pkg::SLOTS_PER_BAND));
   assign wr_addr  = (cfbd_pkg::TABLE_AW'(req_ch.entry_band) << cfbd_pkg::SLOT_AW) |
                     cfbd_pkg::TABLE_AW'(req_ch.entry_slot);
   assign wr_en    = accept && (req_ch.mode == cfbd_pkg::MODE_ENTRY) && entry_ok;

   // table scan
   assign rd_addr        = cfbd_pkg::TABLE_AW'({scan_band_ff, scan_slot_ff});
   assign rd_en          = (state_ff == ST_SCAN) && !issue_done_ff;
   assign last_slot      = scan_slot_ff == cfbd_pkg::SLOT_AW'(cfbd_pkg::SLOTS_PER_BAND - 1);
   assign last_band_slot = last_slot &&
                           (scan_band_ff == cfbd_pkg::BAND_AW'(cfbd_pkg::BAND_COUNT - 1));

   assign fin_band   = found_ff ? cfbd_pkg::BAND_W'(found_band_ff) : '0;
   assign fin_change = found_ff && (!last_valid_ff || (last_band_ff != fin_band));

   cfbd_ram #(
      .WIDTH (cfbd_pkg::MHZ_W),
      .DEPTH (cfbd_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.entry_mhz),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      valid_in      = valid_ff;
      last_valid_in = last_valid_ff;
      last_band_in  = last_band_ff;
      mhz_in        = mhz_ff;
      scan_band_in  = scan_band_ff;
      scan_slot_in  = scan_slot_ff;
      issue_done_in = issue_done_ff;
      pend_in       = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_band_in  = pend_band_ff;
      found_in      = found_ff;
      found_band_in = found_band_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.mode == cfbd_pkg::MODE_ENTRY) begin
                  if (entry_ok) begin
                     valid_in[wr_addr] = req_ch.entry_valid;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
               end else begin
                  if ((pos_base < cfbd_pkg::POS_W'(cfbd_pkg::LINE_LENGTH - 1)) &&
                      (pos_base < cfbd_pkg::POS_W'(cfbd_pkg::HEAD_LEN))) begin
                     head_in[pos_base[cfbd_pkg::HEAD_AW-1:0]] = c;
                  end
                  pos_in = frame_done ? '0 : pos_next;
                  if (!req_ch.auto_selected) begin
                     last_valid_in = 1'b0;
                  end
                  if (req_ch.auto_selected && (mhz_dec != '0)) begin
                     state_in      = ST_SCAN;
                     mhz_in        = mhz_dec;
                     scan_band_in  = '0;
                     scan_slot_in  = '0;
                     issue_done_in = 1'b0;
                  end else begin
                     rsp_valid_in              = 1'b1;
                     rsp_data_in               = '0;
                     rsp_data_in.message_done  = frame_done && prefix_ok;
                     rsp_data_in.mhz           = mhz_dec;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               pend_in       = 1'b1;
               pend_valid_in = valid_ff[rd_addr];
               pend_band_in  = scan_band_ff;
               if (last_band_slot) begin
                  issue_done_in = 1'b1;
               end else if (last_slot) begin
                  scan_slot_in = '0;
                  scan_band_in = cfbd_pkg::BAND_AW'(scan_band_ff + 1'b1);
               end else begin
                  scan_slot_in = cfbd_pkg::SLOT_AW'(scan_slot_ff + 1'b1);
               end
            end
            if (pend_ff && pend_valid_ff && (rd_data == mhz_ff)) begin
               found_in      = 1'b1;
               found_band_in = pend_band_ff;
               state_in      = ST_FINISH;
            end else if (issue_done_ff && !pend_ff) begin
               found_in = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.message_done  = 1'b1;
               rsp_data_in.mhz           = mhz_ff;
               rsp_data_in.band_found    = found_ff;
               rsp_data_in.band          = fin_band;
               rsp_data_in.relay_change  = fin_change;
               rsp_data_in.relay_onehot  =
                  (fin_change && (fin_band < 3'(cfbd_pkg::RELAY_W))) ?
                  cfbd_pkg::RELAY_W'(cfbd_pkg::RELAY_W'(1) << fin_band) : '0;
               if (fin_change) begin
                  last_valid_in = 1'b1;
                  last_band_in  = fin_band;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         for (int i = 0; i < cfbd_pkg::HEAD_LEN; i++) begin
            head_ff[i] <= '0;
         end
         valid_ff      <= '0;
         last_valid_ff <= 1'b0;
         last_band_ff  <= '0;
         issue_done_ff <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         head_ff       <= head_in;
         valid_ff      <= valid_in;
         last_valid_ff <= last_valid_in;
         last_band_ff  <= last_band_in;
         issue_done_ff <= issue_done_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mhz_ff        <= mhz_in;
      scan_band_ff  <= scan_band_in;
      scan_slot_ff  <= scan_slot_in;
      pend_valid_ff <= pend_valid_in;
      pend_band_ff  <= pend_band_in;
      found_ff      <= found_in;
      found_band_ff <= found_band_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.message_done = rsp_data_ff.message_done;
   assign rsp_ch.mhz          = rsp_data_ff.mhz;
   assign rsp_ch.band_found   = rsp_data_ff.band_found;
   assign rsp_ch.band         = rsp_data_ff.band;
   assign rsp_ch.relay_change = rsp_data_ff.relay_change;
   assign rsp_ch.relay_onehot = rsp_data_ff.relay_onehot;

   `CFBD_ASSERT_PROP(a_entry_item_quiet, clock, reset,
      (accept && (req_ch.mode == cfbd_pkg::MODE_ENTRY)) |=>
      (rsp_ch.valid && !rsp_ch.message_done && !rsp_ch.band_found),
      "table write item gave a non-empty result")
   `CFBD_ASSERT_PROP(a_change_needs_match, clock, reset,
      (rsp_ch.valid && rsp_ch.relay_change) |->
      (rsp_ch.band_found && rsp_ch.message_done && (rsp_ch.mhz != '0)),
      "relay change without a matched frame")
   `CFBD_ASSERT_NEVER(a_relay_without_change, clock, reset,
      rsp_ch.valid && !rsp_ch.relay_change && (rsp_ch.relay_onehot != '0),
      "relays driven without a band change")
   `CFBD_ASSERT_PROP(a_scan_in_table, clock, reset,
      (state_ff == ST_SCAN) |->
      (scan_band_ff <= cfbd_pkg::BAND_AW'(cfbd_pkg::BAND_COUNT - 1)),
      "table scan ran past the last band")

endmodule

`default_nettype wire

/* design/cfbd_ram.sv */
`default_nettype none

module cfbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
